// ===== hdl/bcc_pkg.sv =====
// Shared types, constants and helper functions for the balance cascade controller.
// Used by bcc_regs, bcc_mac and balance_cascade_controller; depends on nothing else.

package bcc_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes, in the order of the register map.
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPRIGHT_P    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPRIGHT_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_P      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_I      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_P        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_D        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT  = 3'd7;

  // Register values after reset.
  localparam logic signed [15:0] RST_ANGLE_OFFSET = -16'sd1007;
  localparam logic signed [31:0] RST_UPRIGHT_P    = 32'sd29491200;
  localparam logic signed [31:0] RST_UPRIGHT_D    = 32'sd34364;
  localparam logic signed [31:0] RST_SPEED_P      = -32'sd110559;
  localparam logic signed [31:0] RST_SPEED_I      = -32'sd553;
  localparam logic signed [31:0] RST_YAW_P        = 32'sd0;
  localparam logic signed [31:0] RST_YAW_D        = 32'sd0;
  localparam logic [14:0]        RST_DRIVE_LIMIT  = 15'd7200;

  // Low-pass weights of the speed error filter, Q16.16 (0.3 and 0.7).
  localparam logic signed [31:0] W_NEW = 32'sd19661;
  localparam logic signed [31:0] W_OLD = 32'sd45875;

  // Velocity integral limits.
  localparam logic signed [18:0] INTEG_MAX = 19'sd20000;
  localparam logic signed [18:0] INTEG_MIN = -19'sd20000;

  // Serial multiplier geometry: 32-bit operands, one multiplier bit per cycle.
  localparam int unsigned MUL_W  = 32;
  localparam int unsigned ACC_W  = MUL_W + 2;
  localparam int unsigned PROD_W = ACC_W + MUL_W;
  localparam int unsigned CNT_W  = $clog2(MUL_W);
  localparam int unsigned RND_W  = PROD_W - 16;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic signed [15:0] angle_offset;
    logic signed [31:0] upright_p;
    logic signed [31:0] upright_d;
    logic signed [31:0] speed_p;
    logic signed [31:0] speed_i;
    logic signed [31:0] yaw_p;
    logic signed [31:0] yaw_d;
    logic [14:0]        drive_limit;
  } cfg_t;

  // Sequencer states of one control tick.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILT_GO,
    ST_FILT_WAIT,
    ST_FILT_POST,
    ST_SPD_GO,
    ST_SPD_WAIT,
    ST_SPD_POST,
    ST_DIFF,
    ST_UPR_GO,
    ST_UPR_WAIT,
    ST_UPR_POST,
    ST_TURN_RND,
    ST_TURN_POST,
    ST_OUT
  } bcc_state_e;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [RND_W-1:0] v);
    logic [RND_W-32:0] top;
    top = v[RND_W-1:31];
    if ((top == '0) || (top == '1)) begin
      return v[31:0];
    end else if (v[RND_W-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

  // Clamp a motor mix to the symmetric drive limit.
  function automatic logic signed [15:0] clamp_drive(input logic signed [33:0] m,
                                                     input logic [14:0] lim);
    logic signed [33:0] lim_s;
    logic signed [33:0] res;
    lim_s = $signed({19'd0, lim});
    if (m > lim_s) begin
      res = lim_s;
    end else if (m < -lim_s) begin
      res = -lim_s;
    end else begin
      res = m;
    end
    return res[15:0];
  endfunction

endpackage

// ===== hdl/bcc_regs.sv =====
// Configuration register file of the balance cascade controller.
// Depends on bcc_pkg for the register map, reset values and cfg_t.

module bcc_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bcc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output bcc_pkg::cfg_t                  cfg_o
);

  bcc_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write index; each write replaces one register.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bcc_pkg::REG_ANGLE_OFFSET: cfg_d.angle_offset = $signed(cfg_data_i[15:0]);
        bcc_pkg::REG_UPRIGHT_P:    cfg_d.upright_p    = $signed(cfg_data_i);
        bcc_pkg::REG_UPRIGHT_D:    cfg_d.upright_d    = $signed(cfg_data_i);
        bcc_pkg::REG_SPEED_P:      cfg_d.speed_p      = $signed(cfg_data_i);
        bcc_pkg::REG_SPEED_I:      cfg_d.speed_i      = $signed(cfg_data_i);
        bcc_pkg::REG_YAW_P:        cfg_d.yaw_p        = $signed(cfg_data_i);
        bcc_pkg::REG_YAW_D:        cfg_d.yaw_d        = $signed(cfg_data_i);
        bcc_pkg::REG_DRIVE_LIMIT:  cfg_d.drive_limit  = cfg_data_i[14:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_offset <= bcc_pkg::RST_ANGLE_OFFSET;
      cfg_q.upright_p    <= bcc_pkg::RST_UPRIGHT_P;
      cfg_q.upright_d    <= bcc_pkg::RST_UPRIGHT_D;
      cfg_q.speed_p      <= bcc_pkg::RST_SPEED_P;
      cfg_q.speed_i      <= bcc_pkg::RST_SPEED_I;
      cfg_q.yaw_p        <= bcc_pkg::RST_YAW_P;
      cfg_q.yaw_d        <= bcc_pkg::RST_YAW_D;
      cfg_q.drive_limit  <= bcc_pkg::RST_DRIVE_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/bcc_mac.sv =====
// Bit-serial signed multiply-accumulate unit: a*x + b*y.
// Depends on bcc_pkg for the operand and product widths.

module bcc_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [bcc_pkg::MUL_W-1:0]    mcand_a_i,
  input  logic signed [bcc_pkg::MUL_W-1:0]    mcand_b_i,
  input  logic signed [bcc_pkg::MUL_W-1:0]    mplier_a_i,
  input  logic signed [bcc_pkg::MUL_W-1:0]    mplier_b_i,
  output logic                                done_o,
  output logic signed [bcc_pkg::PROD_W-1:0]   prod_o
);

  localparam int unsigned SUM_W = bcc_pkg::ACC_W + 1;
  localparam logic [bcc_pkg::CNT_W-1:0] CNT_LAST = bcc_pkg::CNT_W'(bcc_pkg::MUL_W - 1);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [bcc_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [bcc_pkg::MUL_W-1:0]  ca_q, cb_q;
  logic [bcc_pkg::MUL_W-1:0]         xa_q, xb_q;
  logic signed [bcc_pkg::ACC_W-1:0]  hi_q;
  logic [bcc_pkg::MUL_W-1:0]         lo_q;
  logic                              last;
  logic signed [SUM_W-1:0]           ext_a, ext_b, add_a, add_b, sum;

  // One multiplier bit of each lane per cycle; the sign bit weighs negative.
  always_comb begin
    last  = (cnt_q == CNT_LAST);
    ext_a = $signed({{(SUM_W - bcc_pkg::MUL_W){ca_q[bcc_pkg::MUL_W-1]}}, ca_q});
    ext_b = $signed({{(SUM_W - bcc_pkg::MUL_W){cb_q[bcc_pkg::MUL_W-1]}}, cb_q});
    add_a = xa_q[0] ? (last ? -ext_a : ext_a) : '0;
    add_b = xb_q[0] ? (last ? -ext_b : ext_b) : '0;
    sum   = $signed({hi_q[bcc_pkg::ACC_W-1], hi_q}) + add_a + add_b;
  end

  // Sequencing of the 32 steps.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand shift registers and the right-shifting accumulator.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ca_q <= mcand_a_i;
      cb_q <= mcand_b_i;
      xa_q <= mplier_a_i;
      xb_q <= mplier_b_i;
      hi_q <= '0;
    end else if (busy_q) begin
      xa_q <= {1'b0, xa_q[bcc_pkg::MUL_W-1:1]};
      xb_q <= {1'b0, xb_q[bcc_pkg::MUL_W-1:1]};
      hi_q <= sum[SUM_W-1:1];
      lo_q <= {sum[0], lo_q[bcc_pkg::MUL_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = $signed({hi_q, lo_q});

endmodule

// ===== hdl/balance_cascade_controller.sv =====
// Top level of the balance cascade controller: tick sequencer, rounding and mix.
// Depends on bcc_pkg, bcc_regs and bcc_mac.
//
//   Channel   Direction  Handshake                    Content
//   s_axis    in         tvalid/tready                one control tick
//   m_axis    out        tvalid/tready                drives and loop terms
//   cfg       in         cfg_we_i, no back-pressure   one register write
//
// An enabled tick makes three passes through the 32-step serial multiplier
// (filter, velocity, upright) and takes one state each for the angle
// difference, turn rounding, turn saturation and the output load. The turn
// products are formed on a second multiplier during the first pass. A
// disabled tick goes from idle straight to the output state. The next
// request is taken once the sequencer is back in idle, also while the
// previous result still waits in the output register; a result that is
// not taken holds the sequencer in its output state. Reset is asynchronous
// and clears the sequencer, the loop state and the registers to their reset
// values.

module balance_cascade_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // count_left, count_right, pitch_angle, balance_rate, yaw_rate,
  // speed_target, turn_target, zero padding
  input  logic [119:0]                   s_axis_tdata,
  // clear_integral, run_enable
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // drive_left, drive_right, upright_term, speed_term, turn_term
  output logic [127:0]                   m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bcc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  bcc_pkg::cfg_t      cfg;
  bcc_pkg::bcc_state_e state_q, state_d;

  // Captured request fields.
  logic signed [17:0] err_q, err_d;
  logic signed [15:0] pitch_q, pitch_d;
  logic signed [15:0] brate_q, brate_d;
  logic signed [15:0] yrate_q, yrate_d;
  logic signed [15:0] tturn_q, tturn_d;
  logic               clr_q, clr_d;

  // Loop state and intermediate terms.
  logic signed [17:0] fe_q, fe_d;
  logic signed [15:0] ei_q, ei_d;
  logic signed [31:0] spd_q, spd_d;
  logic signed [31:0] diff_q, diff_d;
  logic signed [31:0] upr_q, upr_d;
  logic signed [31:0] trn_q, trn_d;
  logic signed [bcc_pkg::RND_W-1:0] rnd_q, rnd_d;

  // Output register.
  logic               out_vld_q, out_vld_d;
  logic [127:0]       out_q, out_d;

  // Serial multiplier hookup.
  logic                                 mac0_start, mac1_start;
  logic signed [bcc_pkg::MUL_W-1:0]     mac0_ca, mac0_cb, mac0_xa, mac0_xb;
  logic signed [bcc_pkg::MUL_W-1:0]     mac1_ca, mac1_cb, mac1_xa, mac1_xb;
  logic                                 mac0_done, mac1_done;
  logic signed [bcc_pkg::PROD_W-1:0]    mac0_prod, mac1_prod;

  // Rounding path and small arithmetic.
  logic signed [bcc_pkg::PROD_W-1:0]    rnd_src;
  logic signed [bcc_pkg::RND_W-1:0]     rnd_shift;
  logic                                 rnd_sticky;
  logic signed [17:0]                   f_val;
  logic signed [18:0]                   integ_sum;
  logic signed [18:0]                   integ_clamp;
  logic signed [40:0]                   diff_wide;
  logic signed [33:0]                   mix1, mix2;
  logic signed [15:0]                   m1_sat, m2_sat, drv_left, drv_right;

  bcc_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Shared multiplier for the filter, velocity and upright sums.
  bcc_mac u_mac_main (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mac0_start),
    .mcand_a_i  (mac0_ca),
    .mcand_b_i  (mac0_cb),
    .mplier_a_i (mac0_xa),
    .mplier_b_i (mac0_xb),
    .done_o     (mac0_done),
    .prod_o     (mac0_prod)
  );

  // Turn loop multiplier, runs alongside the filter pass.
  bcc_mac u_mac_turn (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mac1_start),
    .mcand_a_i  (mac1_ca),
    .mcand_b_i  (mac1_cb),
    .mplier_a_i (mac1_xa),
    .mplier_b_i (mac1_xb),
    .done_o     (mac1_done),
    .prod_o     (mac1_prod)
  );

  // Turn operands are fixed; they are sampled only at the start pulse.
  assign mac1_ca = cfg.yaw_p;
  assign mac1_cb = cfg.yaw_d;
  assign mac1_xa = 32'(tturn_q);
  assign mac1_xb = 32'(yrate_q);

  // Truncation toward zero: floor shift, plus one when negative with lost bits.
  always_comb begin
    rnd_src = (state_q == bcc_pkg::ST_TURN_RND) ? mac1_prod : mac0_prod;
    if (state_q == bcc_pkg::ST_UPR_WAIT) begin
      rnd_shift  = $signed({{7{rnd_src[bcc_pkg::PROD_W-1]}}, rnd_src[bcc_pkg::PROD_W-1:23]});
      rnd_sticky = |rnd_src[22:0];
    end else begin
      rnd_shift  = rnd_src[bcc_pkg::PROD_W-1:16];
      rnd_sticky = |rnd_src[15:0];
    end
    rnd_d = rnd_shift + $signed({{(bcc_pkg::RND_W-1){1'b0}},
                                 rnd_src[bcc_pkg::PROD_W-1] & rnd_sticky});
  end

  // Filter output, integral update and the upright angle error.
  always_comb begin
    f_val     = rnd_q[17:0];
    integ_sum = 19'(ei_q) + 19'(f_val);
    if (integ_sum > bcc_pkg::INTEG_MAX) begin
      integ_clamp = bcc_pkg::INTEG_MAX;
    end else if (integ_sum < bcc_pkg::INTEG_MIN) begin
      integ_clamp = bcc_pkg::INTEG_MIN;
    end else begin
      integ_clamp = integ_sum;
    end
    diff_wide = 41'(pitch_q) - ($signed({{2{spd_q[31]}}, spd_q, 7'd0}) + 41'(cfg.angle_offset));
  end

  // Motor mix and output word.
  always_comb begin
    mix1      = -34'(upr_q) - 34'(trn_q);
    mix2      = -34'(upr_q) + 34'(trn_q);
    m1_sat    = bcc_pkg::clamp_drive(mix1, cfg.drive_limit);
    m2_sat    = bcc_pkg::clamp_drive(mix2, cfg.drive_limit);
    drv_left  = -m1_sat;
    drv_right = m2_sat;
  end

  // Tick sequencer.
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    mac0_start    = 1'b0;
    mac1_start    = 1'b0;
    mac0_ca       = '0;
    mac0_cb       = '0;
    mac0_xa       = '0;
    mac0_xb       = '0;
    err_d         = err_q;
    pitch_d       = pitch_q;
    brate_d       = brate_q;
    yrate_d       = yrate_q;
    tturn_d       = tturn_q;
    clr_d         = clr_q;
    fe_d          = fe_q;
    ei_d          = ei_q;
    spd_d         = spd_q;
    diff_d        = diff_q;
    upr_d         = upr_q;
    trn_d         = trn_q;
    out_d         = out_q;
    out_vld_d     = out_vld_q & ~m_axis_tready;

    unique case (state_q)
      bcc_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          err_d   = 18'($signed(s_axis_tdata[15:0])) + 18'($signed(s_axis_tdata[31:16]))
                  - 18'($signed(s_axis_tdata[96:80]));
          pitch_d = s_axis_tdata[47:32];
          brate_d = s_axis_tdata[63:48];
          yrate_d = s_axis_tdata[79:64];
          tturn_d = s_axis_tdata[112:97];
          clr_d   = s_axis_tuser[0];
          if (s_axis_tuser[1]) begin
            state_d = bcc_pkg::ST_FILT_GO;
          end else begin
            // Disabled tick: zero terms, loop state untouched.
            spd_d   = '0;
            upr_d   = '0;
            trn_d   = '0;
            state_d = bcc_pkg::ST_OUT;
          end
        end
      end
      bcc_pkg::ST_FILT_GO: begin
        mac0_start = 1'b1;
        mac1_start = 1'b1;
        mac0_ca    = bcc_pkg::W_NEW;
        mac0_cb    = bcc_pkg::W_OLD;
        mac0_xa    = 32'(err_q);
        mac0_xb    = 32'(fe_q);
        state_d    = bcc_pkg::ST_FILT_WAIT;
      end
      bcc_pkg::ST_FILT_WAIT: begin
        if (mac0_done) begin
          state_d = bcc_pkg::ST_FILT_POST;
        end
      end
      bcc_pkg::ST_FILT_POST: begin
        fe_d    = f_val;
        ei_d    = clr_q ? '0 : integ_clamp[15:0];
        state_d = bcc_pkg::ST_SPD_GO;
      end
      bcc_pkg::ST_SPD_GO: begin
        mac0_start = 1'b1;
        mac0_ca    = cfg.speed_p;
        mac0_cb    = cfg.speed_i;
        mac0_xa    = 32'(fe_q);
        mac0_xb    = 32'(ei_q);
        state_d    = bcc_pkg::ST_SPD_WAIT;
      end
      bcc_pkg::ST_SPD_WAIT: begin
        if (mac0_done) begin
          state_d = bcc_pkg::ST_SPD_POST;
        end
      end
      bcc_pkg::ST_SPD_POST: begin
        spd_d   = bcc_pkg::sat32(rnd_q);
        state_d = bcc_pkg::ST_DIFF;
      end
      bcc_pkg::ST_DIFF: begin
        diff_d  = bcc_pkg::sat32(bcc_pkg::RND_W'(diff_wide));
        state_d = bcc_pkg::ST_UPR_GO;
      end
      bcc_pkg::ST_UPR_GO: begin
        mac0_start = 1'b1;
        mac0_ca    = cfg.upright_p;
        mac0_cb    = cfg.upright_d;
        mac0_xa    = diff_q;
        mac0_xb    = $signed({{9{brate_q[15]}}, brate_q, 7'd0});
        state_d    = bcc_pkg::ST_UPR_WAIT;
      end
      bcc_pkg::ST_UPR_WAIT: begin
        if (mac0_done) begin
          state_d = bcc_pkg::ST_UPR_POST;
        end
      end
      bcc_pkg::ST_UPR_POST: begin
        upr_d   = bcc_pkg::sat32(rnd_q);
        state_d = bcc_pkg::ST_TURN_RND;
      end
      bcc_pkg::ST_TURN_RND: begin
        state_d = bcc_pkg::ST_TURN_POST;
      end
      bcc_pkg::ST_TURN_POST: begin
        trn_d   = bcc_pkg::sat32(rnd_q);
        state_d = bcc_pkg::ST_OUT;
      end
      bcc_pkg::ST_OUT: begin
        // Wait for the output register to drain before loading a new result.
        if (!out_vld_q || m_axis_tready) begin
          out_d     = {trn_q, spd_q, upr_q, drv_right, drv_left};
          out_vld_d = 1'b1;
          state_d   = bcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bcc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and loop state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bcc_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
      fe_q      <= '0;
      ei_q      <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      fe_q      <= fe_d;
      ei_q      <= ei_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    pitch_q <= pitch_d;
    brate_q <= brate_d;
    yrate_q <= yrate_d;
    tturn_q <= tturn_d;
    clr_q   <= clr_d;
    spd_q   <= spd_d;
    diff_q  <= diff_d;
    upr_q   <= upr_d;
    trn_q   <= trn_d;
    rnd_q   <= rnd_d;
    out_q   <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // A new result appears only as the sequencer leaves its output state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == bcc_pkg::ST_OUT))
    else $error("result offered outside the output state");

  // The velocity integral never leaves its saturation window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ei_q <= 16'sd20000) && (ei_q >= -16'sd20000))
    else $error("velocity integral out of range");

  // The main multiplier finishes only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac0_done |-> (state_q == bcc_pkg::ST_FILT_WAIT || state_q == bcc_pkg::ST_SPD_WAIT ||
                   state_q == bcc_pkg::ST_UPR_WAIT))
    else $error("multiplier finished outside a wait state");

  // Both multipliers start together, so the turn products finish with the filter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac1_done |-> (mac0_done && state_q == bcc_pkg::ST_FILT_WAIT))
    else $error("turn multiplier out of step");

endmodule
